/* sv/circular_hermite_resampler_top_defines.svh */
// Assertion macros shared by the resampler RTL.
`ifndef CIRCULAR_HERMITE_RESAMPLER_TOP_DEFINES_SVH
`define CIRCULAR_HERMITE_RESAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define CRS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define CRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/crs_pkg.sv */
// Constants, beat layout and operation codes of the circular Hermite resampler.
package crs_pkg;

	localparam int STORE_DEPTH   = 4096;
	localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
	localparam int LEN_BITS      = ADDR_BITS + 1;
	localparam int MIN_LENGTH    = 4;
	localparam int SAMPLE_BITS   = 24;
	localparam int FRACTION_BITS = 16;
	localparam int RATE_BITS     = FRACTION_BITS + 3;
	localparam int TOTAL_BITS    = RATE_BITS + 1;
	localparam int CNT_BITS      = $clog2(ADDR_BITS + 1);
	localparam int DIV_BITS      = LEN_BITS + ADDR_BITS;

	// Datapath widths of the Horner evaluation.
	localparam int COEF_BITS = SAMPLE_BITS + 4;
	localparam int MOP_BITS  = SAMPLE_BITS + 6;
	localparam int PROD_BITS = MOP_BITS + FRACTION_BITS + 1;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int RES_BITS  = SUM_BITS - FRACTION_BITS - 1;

	localparam int IN_FIELD_BITS = ADDR_BITS + SAMPLE_BITS + ADDR_BITS + FRACTION_BITS + RATE_BITS;
	localparam int IN_TDATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_WRITE = 2'd0;
	localparam kind_t KIND_PEEK  = 2'd1;
	localparam kind_t KIND_SET   = 2'd2;
	localparam kind_t KIND_STEP  = 2'd3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam logic signed [PROD_BITS-1:0] ROUND_MUL = PROD_BITS'(1) <<< (FRACTION_BITS - 1);
	localparam logic signed [SUM_BITS-1:0]  ROUND_SUM = SUM_BITS'(1) <<< FRACTION_BITS;

	// Input tdata, first field in the lowest bits.
	typedef struct packed {
		logic [IN_TDATA_BITS-IN_FIELD_BITS-1:0] reserved;
		logic [RATE_BITS-1:0]                   rate_step;
		logic [FRACTION_BITS-1:0]               phase_fraction;
		logic [ADDR_BITS-1:0]                   phase_index;
		sample_t                                sample_in;
		logic [ADDR_BITS-1:0]                   write_index;
	} in_beat_t;

endpackage

/* sv/circular_hermite_resampler_top.sv */
// Circular Hermite resampler: sample store, modulo unit, shared multiplier and sequencer.
//
// This block keeps a circular store of up to 4096 signed Q1.23 samples and reads it at a
// fractional phase with 4-point Catmull-Rom Hermite interpolation over the entries at
// phase-1, phase, phase+1 and phase+2, every index wrapped modulo the configured length
// (clamped to 4 .. 4096). Each input beat carries a kind in tuser: write one sample, peek
// at a given phase, set the running phase, or emit at the running phase and then advance
// it by rate_step (16 fraction bits). Peek and emit return one output beat with the
// saturated sample in tdata and a clip flag in tuser; write and set return nothing.
// The block works on one beat at a time and drops s_axis_tready while busy. A write leaves
// the block idle, so writes stream at one per clock. Peek and emit-and-step also wait for
// m_axis_tready when the output register is full. The sequencer's steps come
// from a restoring modulo unit that settles one of 13 remainder bits per cycle (used once
// for set and peek, twice for emit-and-step), four reads through the single store read
// port, and three passes of Horner's rule through one 30 x 17 multiplier. A finished beat
// sits in an output register, so a stalled consumer holds only the sequencer's last state.
// The store has no reset: reading an entry that was never written returns whatever it
// holds. The length register resets to 4096 and may only be written while the block is
// idle.
`include "circular_hermite_resampler_top_defines.svh"

module circular_hermite_resampler_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration: buffer_length.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [crs_pkg::LEN_BITS-1:0]         cfg_data,
	// tdata: write_index, sample_in, phase_index, phase_fraction, rate_step, zero fill.
	// tuser: kind.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [crs_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
	input  logic [1:0]                           s_axis_tuser,
	// tdata: sample_out.
	// tuser: clipped.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [crs_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
	output logic                                 m_axis_tuser
);

	import crs_pkg::*;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_COEF = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	localparam logic [CNT_BITS-1:0] CNT_MOD_START = CNT_BITS'(ADDR_BITS);
	localparam logic [CNT_BITS-1:0] CNT_RD_LAST   = CNT_BITS'(4);

	in_beat_t beat;
	logic     in_fire;
	logic     out_load;

	// Control state.
	logic [2:0]               st_q;
	logic [LEN_BITS-1:0]      len_q;
	logic [ADDR_BITS-1:0]     run_index_q;
	logic [FRACTION_BITS-1:0] run_fraction_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic [1:0]               step_q;
	kind_t                    op_q;
	logic                     stepping_q;
	logic                     out_valid_q;

	// Datapath registers.
	logic [LEN_BITS-1:0]         rem_q;
	logic [DIV_BITS-1:0]         div_q;
	logic [ADDR_BITS-1:0]        i0_q;
	logic [FRACTION_BITS-1:0]    frac_q;
	logic [TOTAL_BITS-1:0]       total_q;
	sample_t                     rd_q;
	sample_t                     xm1_q, x0_q, x1_q, x2_q;
	logic signed [COEF_BITS-1:0] c1_q, c2_q;
	logic signed [MOP_BITS-1:0]  mop_q;
	logic signed [PROD_BITS-1:0] prod_q;
	sample_t                     res_q;
	logic                        clip_q;
	sample_t                     out_data_q;
	logic                        out_clip_q;

	sample_t store_q [STORE_DEPTH];

	assign beat = in_beat_t'(s_axis_tdata);

	// Active length, clamped from below; the write path clamps from above.
	logic [LEN_BITS-1:0] n_act;
	assign n_act = (len_q < LEN_BITS'(MIN_LENGTH)) ? LEN_BITS'(MIN_LENGTH) : len_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (st_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_BITS'(unsigned'(out_data_q));
	assign m_axis_tuser  = out_clip_q;

	// Restoring modulo step: one remainder bit per cycle against the shifted length.
	logic                rem_ge;
	logic [LEN_BITS-1:0] rem_next;
	assign rem_ge   = ({{ADDR_BITS{1'b0}}, rem_q} >= div_q);
	assign rem_next = rem_ge ? (rem_q - div_q[LEN_BITS-1:0]) : rem_q;

	// Neighbor indices around i0, wrapped at the active length.
	logic [LEN_BITS-1:0]  i0_ext, i1_ext, i2_ext, n_m1;
	logic [ADDR_BITS-1:0] im1_idx, i1_idx, i2_idx, rd_addr;
	assign i0_ext  = {1'b0, i0_q};
	assign n_m1    = n_act - LEN_BITS'(1);
	assign im1_idx = (i0_q == '0) ? n_m1[ADDR_BITS-1:0] : (i0_q - ADDR_BITS'(1));
	assign i1_ext  = i0_ext + LEN_BITS'(1);
	assign i1_idx  = (i1_ext == n_act) ? '0 : i1_ext[ADDR_BITS-1:0];
	assign i2_ext  = {1'b0, i1_idx} + LEN_BITS'(1);
	assign i2_idx  = (i2_ext == n_act) ? '0 : i2_ext[ADDR_BITS-1:0];

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    rd_addr = im1_idx;
			2'd1:    rd_addr = i0_q;
			2'd2:    rd_addr = i1_idx;
			default: rd_addr = i2_idx;
		endcase
	end

	// Sample store: one write port used on accept, one registered read port.
	always_ff @(posedge clk) begin
		if (in_fire && s_axis_tuser == KIND_WRITE) begin
			store_q[beat.write_index] <= beat.sample_in;
		end
		rd_q <= store_q[rd_addr];
	end

	// Hermite coefficients, kept at twice their size.
	logic signed [COEF_BITS-1:0] e_m1, e_0, e_1, e_2, d01, c1_w, c2_w, c3_w;
	assign e_m1 = COEF_BITS'(xm1_q);
	assign e_0  = COEF_BITS'(x0_q);
	assign e_1  = COEF_BITS'(x1_q);
	assign e_2  = COEF_BITS'(x2_q);
	assign d01  = e_0 - e_1;
	assign c1_w = e_1 - e_m1;
	assign c2_w = (e_m1 <<< 1) - ((e_0 <<< 2) + e_0) + (e_1 <<< 2) - e_2;
	assign c3_w = (e_2 - e_m1) + ((d01 <<< 1) + d01);

	// Shared multiplier operand and the rounding after each pass.
	logic signed [FRACTION_BITS:0]   f_s;
	logic signed [PROD_BITS-1:0]     p16_w;
	logic signed [SUM_BITS-1:0]      sum_w;
	logic signed [SUM_BITS-1:0]      sum_sh;
	logic signed [RES_BITS-1:0]      res_w;
	logic [RES_BITS-SAMPLE_BITS:0]   res_hi;
	logic                            res_fits;
	assign f_s      = signed'({1'b0, frac_q});
	assign p16_w    = (prod_q + ROUND_MUL) >>> FRACTION_BITS;
	assign sum_w    = SUM_BITS'(prod_q) + (SUM_BITS'(x0_q) <<< (FRACTION_BITS + 1)) + ROUND_SUM;
	assign sum_sh   = sum_w >>> (FRACTION_BITS + 1);
	assign res_w    = RES_BITS'(sum_sh);
	assign res_hi   = res_w[RES_BITS-1:SAMPLE_BITS-1];
	assign res_fits = (&res_hi) || !(|res_hi);

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_IDLE;
			len_q          <= LEN_BITS'(STORE_DEPTH);
			run_index_q    <= '0;
			run_fraction_q <= '0;
			cnt_q          <= '0;
			step_q         <= '0;
			op_q           <= KIND_WRITE;
			stepping_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_q <= (cfg_data > LEN_BITS'(STORE_DEPTH)) ? LEN_BITS'(STORE_DEPTH) : cfg_data;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q       <= s_axis_tuser;
						stepping_q <= 1'b0;
						cnt_q      <= CNT_MOD_START;
						if (s_axis_tuser == KIND_SET) begin
							run_fraction_q <= beat.phase_fraction;
						end
						if (s_axis_tuser != KIND_WRITE) begin
							st_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (cnt_q == '0) begin
						if (stepping_q) begin
							run_index_q    <= rem_next[ADDR_BITS-1:0];
							run_fraction_q <= total_q[FRACTION_BITS-1:0];
							st_q           <= ST_IDLE;
						end else if (op_q == KIND_SET) begin
							run_index_q <= rem_next[ADDR_BITS-1:0];
							st_q        <= ST_IDLE;
						end else begin
							st_q <= ST_RD;
						end
					end else begin
						cnt_q <= cnt_q - CNT_BITS'(1);
					end
				end
				ST_RD: begin
					if (cnt_q == CNT_RD_LAST) begin
						st_q <= ST_COEF;
					end else begin
						cnt_q <= cnt_q + CNT_BITS'(1);
					end
				end
				ST_COEF: begin
					step_q <= '0;
					st_q   <= ST_MUL;
				end
				ST_MUL: begin
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					if (step_q == 2'd2) begin
						st_q <= ST_EMIT;
					end else begin
						step_q <= step_q + 2'd1;
						st_q   <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (op_q == KIND_STEP) begin
							stepping_q <= 1'b1;
							cnt_q      <= CNT_MOD_START;
							st_q       <= ST_MOD;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, steered by the same state.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (in_fire) begin
					rem_q   <= (s_axis_tuser == KIND_STEP) ? {1'b0, run_index_q}
					                                       : {1'b0, beat.phase_index};
					div_q   <= {n_act, {ADDR_BITS{1'b0}}};
					frac_q  <= (s_axis_tuser == KIND_STEP) ? run_fraction_q : beat.phase_fraction;
					total_q <= TOTAL_BITS'(run_fraction_q) + TOTAL_BITS'(beat.rate_step);
				end
			end
			ST_MOD: begin
				rem_q <= rem_next;
				div_q <= div_q >> 1;
				if (cnt_q == '0) begin
					i0_q <= rem_next[ADDR_BITS-1:0];
				end
			end
			ST_RD: begin
				// Read data arrives in the cycle after its address; shift it in from the top.
				if (cnt_q != '0) begin
					xm1_q <= x0_q;
					x0_q  <= x1_q;
					x1_q  <= x2_q;
					x2_q  <= rd_q;
				end
			end
			ST_COEF: begin
				c1_q  <= c1_w;
				c2_q  <= c2_w;
				mop_q <= MOP_BITS'(c3_w);
			end
			ST_MUL: begin
				prod_q <= mop_q * f_s;
			end
			ST_ACC: begin
				case (step_q)
					2'd0:    mop_q <= MOP_BITS'(p16_w) + MOP_BITS'(c2_q);
					2'd1:    mop_q <= MOP_BITS'(p16_w) + MOP_BITS'(c1_q);
					default: begin
						res_q  <= res_fits ? res_w[SAMPLE_BITS-1:0]
						                   : (res_w[RES_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX);
						clip_q <= !res_fits;
					end
				endcase
			end
			ST_EMIT: begin
				if (out_load) begin
					out_data_q <= res_q;
					out_clip_q <= clip_q;
					rem_q      <= i0_ext + LEN_BITS'(total_q[TOTAL_BITS-1:FRACTION_BITS]);
					div_q      <= {n_act, {ADDR_BITS{1'b0}}};
				end
			end
			default: begin
			end
		endcase
	end

	// The wrapped base index must lie inside the active length while the store is read.
	`CRS_ASSERT_SAME(a_base_in_range, st_q == ST_RD, i0_ext < n_act, "base index outside length")

	// A newly set or stepped running index is reduced below the active length.
	`CRS_ASSERT_NEXT(a_run_in_range, (st_q == ST_MOD) && (cnt_q == '0) && (stepping_q || (op_q == KIND_SET)), {1'b0, run_index_q} < n_act, "running index not wrapped")

	// A clipped output beat carries one of the two saturation values.
	`CRS_ASSERT_SAME(a_clip_value, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[SAMPLE_BITS-1:0] == SAMPLE_MAX) || (m_axis_tdata[SAMPLE_BITS-1:0] == SAMPLE_MIN), "clip flag without saturated sample")

endmodule

/* test/circular_hermite_resampler_top_tb.sv */
// Self-checking testbench of the circular Hermite resampler, with random stimulus and idling.
module circular_hermite_resampler_top_tb;
	import crs_pkg::*;

	localparam int IDLE_PCT    = 34;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 60;
	localparam int PHASE_ITEMS = 140;

	typedef struct {
		kind_t    kind;
		in_beat_t fields;
	} stim_beat_t;

	typedef struct {
		sample_t sample;
		logic    clip;
	} hermite_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LEN_BITS-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic m_axis_tuser;

	// Stimulus waiting for the driver, and samples the block still owes us.
	stim_beat_t beats_to_send[$];
	stim_beat_t in_flight;
	hermite_result_t owed_samples[$];

	// Our own picture of the block: store, running phase and length register.
	sample_t shadow_store[STORE_DEPTH];
	logic [ADDR_BITS-1:0] run_idx = '0;
	logic [FRACTION_BITS-1:0] run_frac = '0;
	logic [LEN_BITS-1:0] shadow_length = LEN_BITS'(STORE_DEPTH);

	// Entries that a queued write has already covered, so reads never touch unwritten ones.
	bit filled[STORE_DEPTH];

	// Running phase as the queued beats will leave it, so its reads can be covered early.
	logic [ADDR_BITS-1:0] plan_idx = '0;
	logic [FRACTION_BITS-1:0] plan_frac = '0;

	bit calm = 1'b0;
	int mismatch_count = 0;
	int stall_cycles = 0;

	circular_hermite_resampler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned clamped_length(logic [LEN_BITS-1:0] v);
		if (v < MIN_LENGTH)
			return MIN_LENGTH;
		if (v > STORE_DEPTH)
			return STORE_DEPTH;
		return 32'(v);
	endfunction

	// Floor of (v + half) / 2^s, so halves round toward plus infinity.
	function automatic longint round_half_up(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Catmull-Rom value at idx + frac/2^16, with twice-sized coefficients and Horner's rule.
	function automatic hermite_result_t hermite_at(int unsigned idx, logic [FRACTION_BITS-1:0] frac);
		int unsigned n, i0, im1, i1, i2;
		longint xm1, x0, x1, x2, c1, c2, c3, f, p, hi, lo;
		hermite_result_t r;
		n = clamped_length(shadow_length);
		i0 = idx % n;
		im1 = (i0 == 0) ? n - 1 : i0 - 1;
		i1 = (i0 + 1 == n) ? 0 : i0 + 1;
		i2 = (i1 + 1 == n) ? 0 : i1 + 1;
		xm1 = shadow_store[im1];
		x0 = shadow_store[i0];
		x1 = shadow_store[i1];
		x2 = shadow_store[i2];
		c1 = x1 - xm1;
		c2 = 2 * xm1 - 5 * x0 + 4 * x1 - x2;
		c3 = (x2 - xm1) + 3 * (x0 - x1);
		f = longint'(frac);
		p = round_half_up(c3 * f, FRACTION_BITS);
		p = round_half_up((p + c2) * f, FRACTION_BITS);
		p = round_half_up((p + c1) * f + ((2 * x0) <<< FRACTION_BITS), FRACTION_BITS + 1);
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lo = -hi - 1;
		r.clip = 1'b0;
		if (p > hi) begin
			p = hi;
			r.clip = 1'b1;
		end else if (p < lo) begin
			p = lo;
			r.clip = 1'b1;
		end
		r.sample = sample_t'(p);
		return r;
	endfunction

	// Update the shadow state for one accepted beat and record the sample it owes.
	function automatic void absorb_beat(stim_beat_t b);
		int unsigned n, base, total;
		n = clamped_length(shadow_length);
		case (b.kind)
			KIND_WRITE: begin
				shadow_store[b.fields.write_index] = b.fields.sample_in;
			end
			KIND_PEEK: begin
				owed_samples.push_back(hermite_at(32'(b.fields.phase_index),
					b.fields.phase_fraction));
			end
			KIND_SET: begin
				run_idx = ADDR_BITS'(32'(b.fields.phase_index) % n);
				run_frac = b.fields.phase_fraction;
			end
			default: begin
				base = 32'(run_idx) % n;
				owed_samples.push_back(hermite_at(base, run_frac));
				total = 32'(run_frac) + 32'(b.fields.rate_step);
				run_frac = total[FRACTION_BITS-1:0];
				run_idx = ADDR_BITS'((base + (total >> FRACTION_BITS)) % n);
			end
		endcase
	endfunction

	// Driver: presents the next pending beat, holding it until the block takes it.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				absorb_beat(in_flight);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (beats_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					in_flight = beats_to_send.pop_front();
					s_axis_tdata <= in_flight.fields;
					s_axis_tuser <= in_flight.kind;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each output beat against the oldest owed sample, stalls at random.
	always @(posedge clk) begin
		hermite_result_t want;
		sample_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = sample_t'(m_axis_tdata[SAMPLE_BITS-1:0]);
				if (owed_samples.size() == 0) begin
					$display("%0t: unexpected output beat, expected none, actual %0d clip %0b",
						$time, got, m_axis_tuser);
					mismatch_count++;
				end else begin
					want = owed_samples.pop_front();
					if (got !== want.sample) begin
						$display("%0t: sample_out expected %0d actual %0d",
							$time, want.sample, got);
						mismatch_count++;
					end
					if (m_axis_tuser !== want.clip) begin
						$display("%0t: clipped expected %0b actual %0b",
							$time, want.clip, m_axis_tuser);
						mismatch_count++;
					end
				end
			end
			m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: ends the run when nothing at all has been accepted for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles == STALL_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [ADDR_BITS-1:0] pick_phase(int unsigned n);
		case ($urandom_range(9))
			0: return '0;
			1: return ADDR_BITS'(n - 1);
			2: return '1;
			default: return ADDR_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [FRACTION_BITS-1:0] pick_fraction();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return FRACTION_BITS'($urandom);
		endcase
	endfunction

	// Zero, full scale, some near unity, some below unity, the rest over the whole 19-bit range.
	function automatic logic [RATE_BITS-1:0] pick_rate();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return RATE_BITS'(32'h10000 + $urandom_range(64) - 32);
			4, 5, 6: return RATE_BITS'($urandom_range(32'hFFFF));
			default: return RATE_BITS'($urandom);
		endcase
	endfunction

	// Queues a write of a random sample to an entry that no queued beat has written yet.
	function automatic void cover_entry(int unsigned i);
		stim_beat_t b;
		if (!filled[i]) begin
			b.kind = KIND_WRITE;
			b.fields = '0;
			b.fields.write_index = ADDR_BITS'(i);
			b.fields.sample_in = pick_sample();
			filled[i] = 1'b1;
			beats_to_send.push_back(b);
		end
	endfunction

	// Makes sure the four entries read around idx hold written samples.
	function automatic void cover_reads(int unsigned idx);
		int unsigned n, i0;
		n = clamped_length(shadow_length);
		i0 = idx % n;
		cover_entry((i0 == 0) ? n - 1 : i0 - 1);
		cover_entry(i0);
		cover_entry((i0 + 1) % n);
		cover_entry((i0 + 2) % n);
	endfunction

	task automatic queue_beat(kind_t kind, logic [ADDR_BITS-1:0] widx, sample_t smp,
			logic [ADDR_BITS-1:0] pidx, logic [FRACTION_BITS-1:0] pfrac,
			logic [RATE_BITS-1:0] rate);
		stim_beat_t b;
		int unsigned n, total;
		n = clamped_length(shadow_length);
		b.kind = kind;
		b.fields.reserved = '0;
		b.fields.write_index = widx;
		b.fields.sample_in = smp;
		b.fields.phase_index = pidx;
		b.fields.phase_fraction = pfrac;
		b.fields.rate_step = rate;
		case (kind)
			KIND_WRITE: begin
				filled[widx] = 1'b1;
			end
			KIND_PEEK: begin
				cover_reads(32'(pidx));
			end
			KIND_SET: begin
				plan_idx = ADDR_BITS'(32'(pidx) % n);
				plan_frac = pfrac;
			end
			default: begin
				cover_reads(32'(plan_idx));
				total = 32'(plan_frac) + 32'(rate);
				plan_frac = total[FRACTION_BITS-1:0];
				plan_idx = ADDR_BITS'((32'(plan_idx) % n + (total >> FRACTION_BITS)) % n);
			end
		endcase
		beats_to_send.push_back(b);
	endtask

	// Blocks until every pending beat is taken and every owed sample has come back.
	task automatic wait_until_quiet();
		while (beats_to_send.size() != 0 || s_axis_tvalid || owed_samples.size() != 0)
			@(posedge clk);
	endtask

	// Writes the length register once the block is idle.
	task automatic set_length(logic [LEN_BITS-1:0] value);
		wait_until_quiet();
		repeat (50) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow_length = (value > STORE_DEPTH) ? LEN_BITS'(STORE_DEPTH) : value;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int unsigned count);
		int unsigned n, roll;
		kind_t kind;
		n = clamped_length(shadow_length);
		for (int unsigned i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 25)
				kind = KIND_WRITE;
			else if (roll < 45)
				kind = KIND_PEEK;
			else if (roll < 60)
				kind = KIND_SET;
			else
				kind = KIND_STEP;
			queue_beat(kind, ADDR_BITS'($urandom), pick_sample(), pick_phase(n),
				pick_fraction(), pick_rate());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset length and running phase: the four entries around index zero wrap to 4095.
		queue_beat(KIND_WRITE, 12'd4095, 24'sh123456, '0, '0, '0);
		queue_beat(KIND_WRITE, 12'd0, -24'sd1000000, '0, '0, '0);
		queue_beat(KIND_WRITE, 12'd1, 24'sd2500000, '0, '0, '0);
		queue_beat(KIND_WRITE, 12'd2, 24'sd0, '0, '0, '0);
		queue_beat(KIND_PEEK, '0, '0, 12'd0, 16'h8000, '0);
		queue_beat(KIND_STEP, '0, '0, '0, '0, 19'h18000);

		// Shortest length with full-scale samples that overshoot both ways.
		set_length(13'd4);
		queue_beat(KIND_WRITE, 12'd0, SAMPLE_MIN, '0, '0, '0);
		queue_beat(KIND_WRITE, 12'd1, SAMPLE_MAX, '0, '0, '0);
		queue_beat(KIND_WRITE, 12'd2, SAMPLE_MAX, '0, '0, '0);
		queue_beat(KIND_WRITE, 12'd3, SAMPLE_MIN, '0, '0, '0);
		queue_beat(KIND_PEEK, '0, '0, 12'd1, 16'h8000, '0);
		queue_beat(KIND_PEEK, '0, '0, 12'd3, 16'h8000, '0);
		queue_beat(KIND_PEEK, '0, '0, 12'd1, 16'h0000, '0);
		queue_beat(KIND_PEEK, '0, '0, 12'd2, 16'hFFFF, '0);
		// Phase far beyond the length wraps back into the store.
		queue_beat(KIND_PEEK, '0, '0, 12'd4095, 16'hFFFF, '0);
		queue_beat(KIND_WRITE, 12'd3, -24'sd1, '0, '0, '0);
		queue_beat(KIND_PEEK, '0, '0, 12'd0, 16'h4000, '0);
		queue_beat(KIND_SET, '0, '0, 12'd4095, 16'hFFFF, '0);
		queue_beat(KIND_STEP, '0, '0, '0, '0, 19'h7FFFF);
		queue_beat(KIND_STEP, '0, '0, '0, '0, 19'h00000);
		queue_beat(KIND_STEP, '0, '0, '0, '0, 19'h00001);
		queue_beat(KIND_SET, '0, '0, 12'd2, 16'h0000, '0);
		queue_beat(KIND_STEP, '0, '0, '0, '0, 19'h10000);
		queue_beat(KIND_STEP, '0, '0, '0, '0, 19'h10000);

		// Random phases over several lengths; values outside 4 .. 4096 get clamped.
		// The running phase carries over, so it is often beyond the new length.
		set_length(13'd0);
		random_phase(PHASE_ITEMS);
		set_length(13'd5);
		random_phase(PHASE_ITEMS);
		set_length(13'd17);
		random_phase(PHASE_ITEMS);
		set_length(13'd8191);
		random_phase(PHASE_ITEMS);
		set_length(13'd3);
		random_phase(PHASE_ITEMS);
		set_length(13'd1000);
		wait_until_quiet();
		calm = 1'b1;
		random_phase(PHASE_ITEMS);
		wait_until_quiet();
		calm = 1'b0;
		set_length(13'd4096);
		random_phase(PHASE_ITEMS);

		wait_until_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (owed_samples.size() != 0) begin
			$display("%0t: %0d output beats expected but never seen, actual none",
				$time, owed_samples.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/crs_pkg.sv
sv/circular_hermite_resampler_top.sv
test/circular_hermite_resampler_top_tb.sv
